// File: rtl/mpm_pkg.sv
// ----------------------------------------------------------------------------
// mpm_pkg
// Types and fixed constants shared by the peak meter modules and interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package mpm_pkg;

  localparam int CHAN_W   = 5;
  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int LEVEL_W  = 17;
  localparam int PROD_W   = SAMPLE_W + GAIN_W;   // peak times gain
  localparam int LOG_FRAC = 20;

  localparam logic [GAIN_W-1:0]  GAIN_RESET      = 16'd16384;
  localparam logic [30:0]        DB_PER_LOG2_Q20 = 31'd1616142483;
  localparam logic [LEVEL_W-1:0] LEVEL_FLOOR     = 17'h1_7360;  // -36000
  localparam logic [LEVEL_W-1:0] LEVEL_CEIL      = 17'd3072;
  localparam logic [17:0]        FLOOR_MAG       = 18'd36000;
  localparam logic [17:0]        CEIL_MAG        = 18'd3072;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // One sample update headed for the peak store.
  typedef struct packed {
    logic                valid;
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] mag;
  } mpm_smp_t;

endpackage

`default_nettype wire

// File: rtl/mpm_in_if.sv
// ----------------------------------------------------------------------------
// mpm_in_if
// Input channel of the peak meter: samples and meter ticks.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpm_in_if import mpm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [CHAN_W-1:0]          channel;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_in_block;

  modport source (output valid, operation, channel, sample, last_in_block, input ready);
  modport sink   (input valid, operation, channel, sample, last_in_block, output ready);
endinterface

`default_nettype wire

// File: rtl/mpm_out_if.sv
// ----------------------------------------------------------------------------
// mpm_out_if
// Result channel of the peak meter: one level per channel on a tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpm_out_if import mpm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CHAN_W-1:0]         meter_channel;
  logic signed [LEVEL_W-1:0] level_db;
  logic                      last;

  modport source (output valid, meter_channel, level_db, last, input ready);
  modport sink   (input valid, meter_channel, level_db, last, output ready);
endinterface

`default_nettype wire

// File: rtl/mpm_cfg_if.sv
// ----------------------------------------------------------------------------
// mpm_cfg_if
// Configuration write channel carrying the gain register.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpm_cfg_if import mpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] gain;

  modport source (output valid, gain, input ready);
  modport sink   (input valid, gain, output ready);
endinterface

`default_nettype wire

// File: rtl/mpm_peak_store.sv
// ----------------------------------------------------------------------------
// mpm_peak_store
// Held-peak memory with a two-stage read-modify-write path for samples and
// a read-and-clear port for the meter readout.
// ----------------------------------------------------------------------------
`default_nettype none

module mpm_peak_store import mpm_pkg::*; #(
  parameter int CHANNELS = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire mpm_smp_t                       smp,
  input  wire logic                           rd_en,
  input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
  output logic [SAMPLE_W-1:0]                 rd_peak
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [SAMPLE_W-1:0] mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;

  logic                smp_ok;
  logic                re;
  logic [CW-1:0]       ra;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_vld_r;

  logic                s1_v_r;
  logic [CW-1:0]       s1_addr_r;
  logic [SAMPLE_W-1:0] s1_mag_r;

  logic                wr_v_r;
  logic [CW-1:0]       wr_addr_r;
  logic [SAMPLE_W-1:0] wr_data_r;

  logic [SAMPLE_W-1:0] stored;
  logic [SAMPLE_W-1:0] old_peak;
  logic [SAMPLE_W-1:0] new_peak;

  assign smp_ok = smp.valid && (32'(smp.chan) < CHANNELS);
  assign re     = smp_ok || rd_en;
  assign ra     = smp_ok ? CW'(smp.chan) : rd_addr;

  // Entries never written since reset or the last readout read as zero.
  assign stored   = rd_vld_r ? rd_data_r : '0;
  // The write of the previous cycle is not yet visible in the read data.
  assign old_peak = (wr_v_r && (wr_addr_r == s1_addr_r)) ? wr_data_r : stored;
  assign new_peak = (s1_mag_r > old_peak) ? s1_mag_r : old_peak;
  assign rd_peak  = stored;

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      mem[s1_addr_r] <= new_peak;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      s1_v_r   <= 1'b0;
      wr_v_r   <= 1'b0;
    end else begin
      if (re) begin
        rd_vld_r <= vld_r[ra];
      end
      if (rd_en) begin
        vld_r[rd_addr] <= 1'b0;
      end
      if (s1_v_r) begin
        vld_r[s1_addr_r] <= 1'b1;
      end
      s1_v_r <= smp_ok;
      wr_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= CW'(smp.chan);
    s1_mag_r  <= smp.mag;
    wr_addr_r <= s1_addr_r;
    wr_data_r <= new_peak;
  end

endmodule

`default_nettype wire

// File: rtl/mpm_log_unit.sv
// ----------------------------------------------------------------------------
// mpm_log_unit
// Iterative level converter: peak times gain, leading-one normalization,
// log2 by repeated squaring, scaling to 1/256 dB with rounding and clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module mpm_log_unit import mpm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [SAMPLE_W-1:0]   peak,
  input  wire logic [GAIN_W-1:0]     gain,
  output logic                       done,
  output logic signed [LEVEL_W-1:0]  level
);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_NORM = 3'd1;
  localparam logic [2:0] L_SQR  = 3'd2;
  localparam logic [2:0] L_ABS  = 3'd3;
  localparam logic [2:0] L_MUL  = 3'd4;
  localparam logic [2:0] L_RND  = 3'd5;

  logic [2:0]          st_r;
  logic [4:0]          step_r;
  logic [PROD_W-1:0]   x_r;
  logic [5:0]          sh_r;
  logic [31:0]         m_r;
  logic [LOG_FRAC-1:0] frac_r;
  logic                zero_r;
  logic                neg_r;
  logic [25:0]         dmag_r;
  logic [56:0]         prod_r;
  logic [LEVEL_W-1:0]  level_r;
  logic                done_r;

  logic [PROD_W-1:0]   x_nxt;
  logic [5:0]          sh_add;
  logic [63:0]         sq;
  logic [32:0]         sq_top;
  logic [6:0]          int_part;
  logic [26:0]         d_val;
  logic [26:0]         d_mag;
  logic [57:0]         rsum;
  logic [17:0]         r_mag;
  logic [LEVEL_W-1:0]  lvl;

  // One step of a binary search for the leading one.
  always_comb begin
    x_nxt  = x_r;
    sh_add = 6'd0;
    unique case (step_r[2:0])
      3'd0: if (x_r[39:8] == '0) begin
        x_nxt = {x_r[7:0], 32'd0};  sh_add = 6'd32;
      end
      3'd1: if (x_r[39:24] == '0) begin
        x_nxt = {x_r[23:0], 16'd0}; sh_add = 6'd16;
      end
      3'd2: if (x_r[39:32] == '0) begin
        x_nxt = {x_r[31:0], 8'd0};  sh_add = 6'd8;
      end
      3'd3: if (x_r[39:36] == '0) begin
        x_nxt = {x_r[35:0], 4'd0};  sh_add = 6'd4;
      end
      3'd4: if (x_r[39:38] == '0) begin
        x_nxt = {x_r[37:0], 2'd0};  sh_add = 6'd2;
      end
      3'd5: if (!x_r[39]) begin
        x_nxt = {x_r[38:0], 1'b0};  sh_add = 6'd1;
      end
      default: begin
        x_nxt  = x_r;
        sh_add = 6'd0;
      end
    endcase
  end

  assign sq     = m_r * m_r;
  assign sq_top = sq[63:31];

  // Exponent 39 - shift, less 37, joined with the fraction bits.
  assign int_part = 7'd2 - {1'b0, sh_r};
  assign d_val    = {int_part, frac_r};
  assign d_mag    = d_val[26] ? (27'd0 - d_val) : d_val;

  assign rsum  = {1'b0, prod_r} + (58'd1 << 39);
  assign r_mag = rsum[57:40];

  always_comb begin
    if (zero_r) begin
      lvl = LEVEL_FLOOR;
    end else if (neg_r) begin
      lvl = (r_mag > FLOOR_MAG) ? LEVEL_FLOOR : (17'd0 - r_mag[16:0]);
    end else begin
      lvl = (r_mag > CEIL_MAG) ? LEVEL_CEIL : r_mag[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        L_IDLE: if (start) begin
          st_r   <= L_NORM;
          step_r <= '0;
        end
        L_NORM: begin
          if (step_r == 5'd5) begin
            st_r   <= L_SQR;
            step_r <= '0;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        L_SQR: begin
          if (step_r == 5'(LOG_FRAC - 1)) begin
            st_r <= L_ABS;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        L_ABS: st_r <= L_MUL;
        L_MUL: st_r <= L_RND;
        L_RND: begin
          st_r   <= L_IDLE;
          done_r <= 1'b1;
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      L_IDLE: begin
        x_r    <= peak * gain;
        zero_r <= (peak == '0) || (gain == '0);
        sh_r   <= '0;
        frac_r <= '0;
      end
      L_NORM: begin
        x_r  <= x_nxt;
        sh_r <= sh_r + sh_add;
        m_r  <= x_nxt[39:8];
      end
      L_SQR: begin
        frac_r <= {frac_r[LOG_FRAC-2:0], sq_top[32]};
        m_r    <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
      end
      L_ABS: begin
        neg_r  <= d_val[26];
        dmag_r <= d_mag[25:0];
      end
      L_MUL: prod_r <= dmag_r * DB_PER_LOG2_Q20;
      L_RND: level_r <= lvl;
      default: level_r <= level_r;
    endcase
  end

  assign done  = done_r;
  assign level = $signed(level_r);

endmodule

`default_nettype wire

// File: rtl/multichannel_peak_meter_db.sv
// ----------------------------------------------------------------------------
// multichannel_peak_meter_db
// Per-channel audio peak meter with a level readout in 1/256 dB.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries two kinds of transfer. A sample transfer raises
// the held peak of its channel to the sample's magnitude and produces no
// result; samples are taken one per cycle while no readout runs, and a
// sample for a channel at or above CHANNELS is dropped. A tick transfer
// starts a readout: every channel, from 0 upward, is read from the peak
// memory and cleared, converted to round(5120*log10(peak*gain/2^37)) and
// sent as one result transfer; the last one carries last = 1. A zero peak
// reports -36000 and levels above +12 dB report 3072.
// Each channel of a readout reads the peak and starts the converter, which
// runs six normalization steps and twenty squarings on one 32x32
// multiplier, then scales, rounds and hands the level over. The input
// stays not ready from the tick until the last result sits in the output
// register. The output register holds a result while the receiver stalls;
// the converter pauses until it is taken, and new input is taken as soon
// as the final result is loaded. The gain register is written through the
// configuration channel, which is always ready.
// Reset (synchronous, active low) clears all held peaks at once through
// per-entry valid bits, sets the gain to unity and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_peak_meter_db import mpm_pkg::*; #(
  parameter int CHANNELS = 24
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mpm_in_if.sink     in_st,
  mpm_out_if.source  out_st,
  mpm_cfg_if.sink    cfg_wr
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Readout sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_LD   = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]         st_r;
  logic [CW-1:0]      ch_r;
  logic [GAIN_W-1:0]  gain_r;

  logic               out_v_r;
  logic [CHAN_W-1:0]  out_ch_r;
  logic [LEVEL_W-1:0] out_lvl_r;
  logic               out_last_r;

  logic               in_acc;
  logic               is_last;
  logic               out_free;
  logic               out_load;
  mpm_smp_t           smp;
  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W-1:0] rd_peak;
  logic               log_done;
  logic signed [LEVEL_W-1:0] log_level;

  assign in_st.ready  = (st_r == S_IDLE);
  assign cfg_wr.ready = 1'b1;
  assign in_acc       = in_st.valid && in_st.ready;
  assign is_last      = (ch_r == CW'(CHANNELS - 1));
  assign out_free     = !out_v_r || out_st.ready;
  // A finished level moves into the output register once it is free.
  assign out_load     = (st_r == S_OUT) && out_free;

  // Magnitude of the sample; the most negative value maps to 2^23.
  assign mag = in_st.sample[SAMPLE_W-1] ? (SAMPLE_W'(0) - SAMPLE_W'(in_st.sample))
                                        : SAMPLE_W'(in_st.sample);

  assign smp.valid = in_acc && (in_st.operation == OP_SAMPLE);
  assign smp.chan  = in_st.channel;
  assign smp.mag   = mag;

  mpm_peak_store #(
    .CHANNELS (CHANNELS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .smp     (smp),
    .rd_en   (st_r == S_RD),
    .rd_addr (ch_r),
    .rd_peak (rd_peak)
  );

  mpm_log_unit u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == S_LD),
    .peak  (rd_peak),
    .gain  (gain_r),
    .done  (log_done),
    .level (log_level)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_wr.valid) begin
      gain_r <= cfg_wr.gain;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      ch_r    <= '0;
      out_v_r <= 1'b0;
    end else begin
      // The output stays full while the receiver stalls or a new level loads.
      out_v_r <= out_load || (out_v_r && !out_st.ready);
      unique case (st_r)
        S_IDLE: if (in_acc && (in_st.operation == OP_TICK)) begin
          ch_r <= '0;
          st_r <= S_RD;
        end
        S_RD:   st_r <= S_LD;
        S_LD:   st_r <= S_CALC;
        S_CALC: if (log_done) begin
          st_r <= S_OUT;
        end
        S_OUT: if (out_free) begin
          if (is_last) begin
            st_r <= S_IDLE;
          end else begin
            ch_r <= ch_r + CW'(1);
            st_r <= S_RD;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r   <= CHAN_W'(ch_r);
      out_lvl_r  <= log_level;
      out_last_r <= is_last;
    end
  end

  assign out_st.valid         = out_v_r;
  assign out_st.meter_channel = out_ch_r;
  assign out_st.level_db      = $signed(out_lvl_r);
  assign out_st.last          = out_last_r;

endmodule

`default_nettype wire

// File: tb/mpm_level_checker.sv
// ----------------------------------------------------------------------------
// mpm_level_checker
// Watches the peak meter's channels, predicts every level and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mpm_level_checker import mpm_pkg::*; #(
  parameter int CHANNELS = 24
) (
  input  logic clk,
  input  logic rst_n,
  mpm_in_if    in_mon,
  mpm_out_if   out_mon,
  mpm_cfg_if   cfg_mon,
  output int   mismatches,
  output int   outstanding
);

  localparam int     FULL_SCALE_LOG2 = 37;  // peak * gain at 0 dB is 2^37
  localparam int     ROUND_SHIFT     = 40;  // Q20 log times Q20 scale
  localparam longint FLOOR_DB        = -36000;
  localparam longint CEIL_DB         = 3072;
  localparam int     REPORT_LIMIT    = 10;

  typedef struct {
    logic [CHAN_W-1:0]         chan;
    logic signed [LEVEL_W-1:0] level;
    logic                      last;
  } meter_reading_t;

  logic [SAMPLE_W-1:0] peak_hold [CHANNELS];
  logic [GAIN_W-1:0]   gain_reg;
  meter_reading_t      readout_q [$];
  int                  fails = 0;

  // Level in 1/256 dB: the log2 of peak * gain in Q20, from the top set bit
  // and twenty squarings of the Q1.31 mantissa, scaled and rounded.
  function automatic logic signed [LEVEL_W-1:0] level_in_db(
    input logic [SAMPLE_W-1:0] peak,
    input logic [GAIN_W-1:0]   g
  );
    logic [63:0]         x;
    logic [63:0]         mant;
    logic [LOG_FRAC-1:0] frac;
    int                  msb;
    longint              log_dist;
    longint              scaled;
    longint              mag;
    longint              rounded;
    x = 64'(peak) * 64'(g);
    if (x == 0) return LEVEL_FLOOR;
    msb = 0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) msb = i;
    end
    mant = (msb <= 31) ? (x << (31 - msb)) : (x >> (msb - 31));
    frac = '0;
    for (int k = 0; k < LOG_FRAC; k++) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        mant    = mant >> 1;
      end
    end
    log_dist = (longint'(msb) <<< LOG_FRAC) + longint'({44'd0, frac})
             - (longint'(FULL_SCALE_LOG2) <<< LOG_FRAC);
    scaled  = log_dist * longint'(DB_PER_LOG2_Q20);
    mag     = (scaled < 0) ? -scaled : scaled;
    rounded = (mag + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (scaled < 0) rounded = -rounded;
    if (rounded < FLOOR_DB) rounded = FLOOR_DB;
    if (rounded > CEIL_DB) rounded = CEIL_DB;
    return LEVEL_W'(rounded);
  endfunction

  task automatic flag(input string what);
    fails++;
    if (fails <= REPORT_LIMIT) $display("[%0t] %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    meter_reading_t      want;
    logic [SAMPLE_W-1:0] mag;
    if (!rst_n) begin
      foreach (peak_hold[i]) peak_hold[i] = '0;
      gain_reg = GAIN_RESET;
      readout_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) gain_reg = cfg_mon.gain;

      // Results are checked before a tick in the same cycle adds new ones.
      if (out_mon.valid && out_mon.ready) begin
        if (readout_q.size() == 0) begin
          flag($sformatf("unexpected level: ch %0d level %0d last %0b",
                         out_mon.meter_channel, out_mon.level_db, out_mon.last));
        end else begin
          want = readout_q.pop_front();
          if (out_mon.meter_channel !== want.chan || out_mon.level_db !== want.level ||
              out_mon.last !== want.last) begin
            flag($sformatf("level mismatch: expected ch %0d level %0d last %0b, got ch %0d level %0d last %0b",
                           want.chan, want.level, want.last,
                           out_mon.meter_channel, out_mon.level_db, out_mon.last));
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OP_SAMPLE) begin
          mag = in_mon.sample[SAMPLE_W-1] ? -in_mon.sample : in_mon.sample;
          if (in_mon.channel < CHANNELS) begin
            if (mag > peak_hold[in_mon.channel]) peak_hold[in_mon.channel] = mag;
          end
        end else begin
          for (int c = 0; c < CHANNELS; c++) begin
            want.chan  = CHAN_W'(c);
            want.level = level_in_db(peak_hold[c], gain_reg);
            want.last  = (c == CHANNELS - 1);
            readout_q.push_back(want);
            peak_hold[c] = '0;
          end
        end
      end
    end
    outstanding <= readout_q.size();
    mismatches  <= fails;
  end

endmodule

// File: tb/tb_multichannel_peak_meter_db.sv
// ----------------------------------------------------------------------------
// tb_multichannel_peak_meter_db
// Stimulus and verdict for the multichannel peak meter.
// ----------------------------------------------------------------------------
// A directed part covers the sample extremes, held peaks, ignored channels,
// and the zero, tiny and saturating levels. Random bursts of samples ended
// by a tick then run under several gain settings. Both handshake sides stall
// at random except for one quiet phase. The checker beside the block
// predicts each readout and counts mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_multichannel_peak_meter_db;
  import mpm_pkg::*;

  localparam int CHANNELS       = 24;
  localparam int STALL_PCT      = 8;     // chance in percent of an idle cycle
  localparam int SETTLE_CYCLES  = 50;    // quiet time before a gain write
  localparam int DRAIN_CYCLES   = 200;   // watch for stray results at the end
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all
  localparam int PHASE_ITEMS    = 50;
  localparam int PHASES         = 6;

  logic clk;
  logic rst_n;
  bit   steady;        // when set, neither side inserts idle cycles
  int   mismatches;
  int   outstanding;
  int   quiet_cycles;

  mpm_in_if  in_if ();
  mpm_out_if out_if ();
  mpm_cfg_if cfg_if ();

  multichannel_peak_meter_db #(.CHANNELS(CHANNELS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_st  (in_if),
    .out_st (out_if),
    .cfg_wr (cfg_if)
  );

  mpm_level_checker #(.CHANNELS(CHANNELS)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_mon     (cfg_if),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver drops ready in about one cycle of twelve, never while the
  // steady phase runs.
  always @(posedge clk) begin
    out_if.ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
  end

  // The watchdog ends a run that hangs. The longest planned pause is the
  // drain at the end, so the limit sits far above any gap of a correct run.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** multichannel_peak_meter_db: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one input transfer and returns at the clock edge that accepts
  // it. Any idle cycles come first, so a gap can fall between any two items,
  // including just before a tick.
  task automatic send_item(input logic op, input logic [CHAN_W-1:0] ch,
                           input logic [SAMPLE_W-1:0] smp, input logic blk_end);
    while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.operation     <= op;
    in_if.channel       <= ch;
    in_if.sample        <= smp;
    in_if.last_in_block <= blk_end;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Waits until every predicted level has arrived. The checker's count is
  // updated at the edge after a transfer, hence the first extra edge.
  task automatic wait_idle(input int extra);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // The gain is only changed while no readout runs.
  task automatic set_gain(input logic [GAIN_W-1:0] g);
    wait_idle(SETTLE_CYCLES);
    cfg_if.valid <= 1'b1;
    cfg_if.gain  <= g;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Sample values are spread over the whole dB range: a random word is
  // shifted down arithmetically so that small magnitudes are as common as
  // large ones. One in ten is a corner value.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] raw;
    raw = SAMPLE_W'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0:       return 24'h000000;
        1:       return 24'h000001;
        2:       return 24'hFFFFFF;
        3:       return 24'h7FFFFF;
        default: return 24'h800000;
      endcase
    end
    return raw >>> $urandom_range(0, SAMPLE_W - 1);
  endfunction

  // Random traffic in the shape the host produces: a burst of samples over
  // the channels and then a tick. Empty bursts give back-to-back ticks and a
  // few samples go to channels that do not exist. The ignored fields of a
  // tick carry random bits.
  task automatic random_traffic(input int n_items);
    int                  counted;
    int                  burst;
    logic [CHAN_W-1:0]   ch;
    counted = 0;
    while (counted < n_items) begin
      burst = $urandom_range(0, 30);
      for (int b = 0; b < burst; b++) begin
        if ($urandom_range(0, 99) < 5) ch = CHAN_W'($urandom_range(CHANNELS, 31));
        else ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
        send_item(OP_SAMPLE, ch, pick_sample(), b == burst - 1);
        if (ch < CHANNELS) counted++;
      end
      send_item(OP_TICK, CHAN_W'($urandom), SAMPLE_W'($urandom), 1'($urandom));
      counted++;
    end
  endtask

  initial begin
    logic [GAIN_W-1:0] phase_gain;
    rst_n                <= 1'b0;
    steady                = 1'b0;
    in_if.valid          <= 1'b0;
    in_if.operation      <= OP_SAMPLE;
    in_if.channel        <= '0;
    in_if.sample         <= '0;
    in_if.last_in_block  <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.gain          <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Right after reset every channel reads the floor at unity gain.
    send_item(OP_TICK, '0, '0, 1'b0);

    // Full-scale magnitudes of both signs, the smallest ones, a peak that
    // smaller and equal samples must not lower, and samples for channels
    // past the last one, which must leave every peak alone.
    send_item(OP_SAMPLE, 5'd0,  24'h7FFFFF, 1'b0);
    send_item(OP_SAMPLE, 5'd1,  24'h800000, 1'b1);
    send_item(OP_SAMPLE, 5'd2,  24'h000001, 1'b0);
    send_item(OP_SAMPLE, 5'd3,  24'hFFFFFF, 1'b0);
    send_item(OP_SAMPLE, 5'd4,  24'h000100, 1'b0);
    send_item(OP_SAMPLE, 5'd4,  24'h000010, 1'b0);
    send_item(OP_SAMPLE, 5'd4,  24'hFFFF00, 1'b0);
    send_item(OP_SAMPLE, 5'd23, 24'h400000, 1'b1);
    send_item(OP_SAMPLE, 5'd24, 24'h7FFFFF, 1'b0);
    send_item(OP_SAMPLE, 5'd31, 24'h800000, 1'b1);
    send_item(OP_SAMPLE, 5'd22, 24'h555555, 1'b0);
    send_item(OP_SAMPLE, 5'd21, 24'hAAAAAA, 1'b0);
    send_item(OP_TICK, 5'd31, 24'hFFFFFF, 1'b1);
    // The readout cleared every peak, so a second tick reads the floor.
    send_item(OP_TICK, '0, '0, 1'b0);

    // Maximum gain drives full-scale peaks past +12 dB into saturation.
    set_gain(16'hFFFF);
    send_item(OP_SAMPLE, 5'd0, 24'h800000, 1'b0);
    send_item(OP_SAMPLE, 5'd1, 24'h7FFFFF, 1'b0);
    send_item(OP_SAMPLE, 5'd5, 24'h000001, 1'b1);
    send_item(OP_TICK, '0, '0, 1'b0);

    // A gain of one makes tiny products fall below the floor.
    set_gain(16'd1);
    send_item(OP_SAMPLE, 5'd0, 24'h000001, 1'b0);
    send_item(OP_SAMPLE, 5'd1, 24'h800000, 1'b1);
    send_item(OP_TICK, '0, '0, 1'b0);

    // Zero gain reads the floor even for a full-scale peak.
    set_gain(16'd0);
    send_item(OP_SAMPLE, 5'd7, 24'h7FFFFF, 1'b1);
    send_item(OP_TICK, '0, '0, 1'b0);

    // Random phases, each under its own gain. The third runs without any
    // idle cycle on either side.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_gain = GAIN_RESET;
        2:       phase_gain = GAIN_W'($urandom_range(1, 1023));
        3:       phase_gain = 16'hFFFF;
        5:       phase_gain = GAIN_W'($urandom_range(16384, 65535));
        default: phase_gain = GAIN_W'($urandom);
      endcase
      set_gain(phase_gain);
      steady = (p == 2);
      random_traffic(PHASE_ITEMS);
    end
    steady = 1'b0;

    wait_idle(DRAIN_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** multichannel_peak_meter_db: PASSED **");
    end else begin
      $display("** multichannel_peak_meter_db: FAILED **");
    end
    $finish;
  end

endmodule
